[src/kfli_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfli_pkg: shared types and constants of the keyframe interpolator
// Command codes, sequencer states and the divider request/status bundles.
// ----------------------------------------------------------------------------
package kfli_pkg;

  localparam int NCH    = 5;   // channels per keyframe
  localparam int CH_W   = 3;   // channel counter width
  localparam int STEP_W = 16;  // steps_per_segment width

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SAVE = 2'd1;
  localparam logic [1:0] CMD_PLAY = 2'd2;

  localparam logic [STEP_W-1:0] STEPS_RESET = 16'd60;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAVE,
    ST_RDA,
    ST_RDB,
    ST_DIFF,
    ST_DIV,
    ST_ADD,
    ST_OUT
  } kfli_state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] divisor;
  } kfli_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } kfli_div_sts_t;

endpackage

[src/kfli_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfli_div: serial signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module kfli_div #(
  parameter int DW = 33
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kfli_pkg::kfli_div_req_t req,
  input  logic [DW-1:0]          dividend,
  output kfli_pkg::kfli_div_sts_t sts,
  output logic [DW-1:0]          quotient
);
  import kfli_pkg::*;

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]     mag_r;
  logic [STEP_W-1:0] rem_r;
  logic [STEP_W-1:0] div_r;
  logic              neg_r;
  logic [CNTW-1:0]   cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [STEP_W:0]   rem_sh;
  logic [STEP_W+1:0] trial;
  logic              ge;
  logic [DW-1:0]     abs_in;

  assign abs_in = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
  assign rem_sh = {rem_r, mag_r[DW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, div_r};
  assign ge     = ~trial[STEP_W+1];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: shift the magnitude out, quotient bits in
  always_ff @(posedge clk) begin
    if (req.start) begin
      mag_r <= abs_in;
      rem_r <= '0;
      div_r <= req.divisor;
      neg_r <= dividend[DW-1];
    end else if (busy_r) begin
      mag_r <= {mag_r[DW-2:0], ge};
      rem_r <= ge ? trial[STEP_W-1:0] : rem_sh[STEP_W-1:0];
    end
  end

  assign quotient = neg_r ? (~mag_r + DW'(1)) : mag_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

[src/keyframe_linear_interpolator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_core: keyframe store with linear playback
// Saves up to MAX_KEYS five-channel poses and steps the current pose between
// adjacent keyframes by per-tick increments found with a serial divider.
// ----------------------------------------------------------------------------
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+------------------------------
//  command  | in_command, in_pose_*               | beat taken when start && !busy
//  result   | out_cur_*, out_is_playing,          | out_valid high one cycle,
//           | out_keys_stored, out_finished       | no back-pressure
//  config   | cfg_we, cfg_wdata                   | written when cfg_we high
//
//  A save steps through ST_SAVE per channel, a tick that adds through ST_ADD
//  per channel; a plain tick or play-stop goes straight to ST_OUT. A play
//  start or a segment change reloads five increments, one channel at a time
//  through the shared divider, which yields one quotient bit per cycle.
//  busy stays high from the accepted beat until its result strobe.
//  Reset is synchronous, active low; the keyframe memory is not cleared.
//  The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_core #(
  parameter int MAX_KEYS     = 8,
  parameter int CHANNEL_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_command,
  input  logic signed [31:0]        in_pose_x,
  input  logic signed [31:0]        in_pose_y,
  input  logic signed [31:0]        in_pose_z,
  input  logic signed [31:0]        in_pose_rot_a,
  input  logic signed [31:0]        in_pose_rot_b,
  // result channel
  output logic                      out_valid,
  output logic signed [31:0]        out_cur_x,
  output logic signed [31:0]        out_cur_y,
  output logic signed [31:0]        out_cur_z,
  output logic signed [31:0]        out_cur_rot_a,
  output logic signed [31:0]        out_cur_rot_b,
  output logic                      out_is_playing,
  output logic [3:0]                out_keys_stored,
  output logic                      out_finished,
  // configuration
  input  logic                      cfg_we,
  input  logic [kfli_pkg::STEP_W-1:0] cfg_wdata
);
  import kfli_pkg::*;

  localparam int CW    = CHANNEL_BITS;
  localparam int DW    = CW + 1;                     // difference width
  localparam int SW    = $clog2(MAX_KEYS);           // segment index width
  localparam int SCW   = $clog2(MAX_KEYS + 1);       // key count width
  localparam int DEPTH = MAX_KEYS * NCH;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = (CW > 32) ? CW : 32;        // extension width for I/O
  localparam int KW    = (SCW > 4) ? SCW : 4;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  kfli_state_t       state_r, state_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [SW-1:0]     seg_r, seg_nxt;
  logic [SCW-1:0]    saved_r, saved_nxt;
  logic [STEP_W-1:0] tick_r, tick_nxt;
  logic              play_r, play_nxt;
  logic              done_r, done_nxt;
  logic              load_pose_r, load_pose_nxt;
  logic [STEP_W-1:0] steps_r;

  logic [CW-1:0]     pose_r [NCH];
  logic [CW-1:0]     inc_r  [NCH];
  logic [CW-1:0]     pin_r  [NCH];
  logic [CW-1:0]     a_r;
  logic [CW-1:0]     rdata_r;

  // keyframe memory, channel-major within a key
  logic [CW-1:0]     mem [DEPTH];

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [AW-1:0] addr_of(input logic [SCW-1:0] key,
                                            input logic [CH_W-1:0] ch);
    addr_of = AW'(key) * AW'(NCH) + AW'(ch);
  endfunction

  logic [31:0]        in_pose [NCH];
  logic [CW-1:0]      in_ch   [NCH];
  logic [STEP_W-1:0]  eff_steps;
  logic [SCW:0]       seg_inc;
  logic               pair_left;
  logic               save_ok;
  logic               accept;

  assign in_pose[0] = in_pose_x;
  assign in_pose[1] = in_pose_y;
  assign in_pose[2] = in_pose_z;
  assign in_pose[3] = in_pose_rot_a;
  assign in_pose[4] = in_pose_rot_b;

  // truncate or sign-extend each input channel to CHANNEL_BITS
  for (genvar c = 0; c < NCH; c++) begin : g_in
    logic [EW-1:0] ext;
    assign ext      = EW'($signed(in_pose[c]));
    assign in_ch[c] = ext[CW-1:0];
  end

  assign accept    = start && !busy;
  assign eff_steps = (steps_r == '0) ? STEP_W'(1) : steps_r;
  assign seg_inc   = (SCW+1)'(seg_r) + (SCW+1)'(1);
  // another pair exists when the next segment's upper key is stored
  assign pair_left = (seg_inc + (SCW+1)'(2)) <= (SCW+1)'(saved_r);
  assign save_ok   = saved_r < SCW'(MAX_KEYS);

  // --------------------------------------------------------------------------
  // Shared adder: keyframe difference or pose advance
  // --------------------------------------------------------------------------
  logic          op_sub;
  logic [DW-1:0] opa, opb, sum;

  assign op_sub = (state_r == ST_DIFF);
  assign opa    = op_sub ? DW'($signed(rdata_r)) : DW'(pose_r[ch_r]);
  assign opb    = op_sub ? DW'($signed(a_r))     : DW'(inc_r[ch_r]);
  assign sum    = opa + (op_sub ? ~opb : opb) + DW'(op_sub);

  // --------------------------------------------------------------------------
  // Divider
  // --------------------------------------------------------------------------
  kfli_div_req_t div_req;
  kfli_div_sts_t div_sts;
  logic [DW-1:0] div_q;

  assign div_req.start   = (state_r == ST_DIFF);
  assign div_req.divisor = eff_steps;

  kfli_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (sum),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      seg_r       <= '0;
      saved_r     <= '0;
      tick_r      <= '0;
      play_r      <= 1'b0;
      done_r      <= 1'b0;
      load_pose_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      seg_r       <= seg_nxt;
      saved_r     <= saved_nxt;
      tick_r      <= tick_nxt;
      play_r      <= play_nxt;
      done_r      <= done_nxt;
      load_pose_r <= load_pose_nxt;
    end
  end

  logic          last_ch;
  logic [AW-1:0] raddr;

  assign last_ch = (ch_r == CH_W'(NCH - 1));

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    seg_nxt       = seg_r;
    saved_nxt     = saved_r;
    tick_nxt      = tick_r;
    play_nxt      = play_r;
    done_nxt      = done_r;
    load_pose_nxt = load_pose_r;
    raddr         = addr_of(SCW'(seg_r), ch_r);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          done_nxt = 1'b0;
          ch_nxt   = '0;
          unique case (in_command)
            CMD_SAVE: begin
              state_nxt = save_ok ? ST_SAVE : ST_OUT;
            end
            CMD_PLAY: begin
              if (!play_r && saved_r >= SCW'(2)) begin
                play_nxt      = 1'b1;
                seg_nxt       = '0;
                tick_nxt      = '0;
                load_pose_nxt = 1'b1;
                state_nxt     = ST_RDA;
              end else begin
                play_nxt  = 1'b0;
                state_nxt = ST_OUT;
              end
            end
            CMD_TICK: begin
              if (!play_r) begin
                state_nxt = ST_OUT;
              end else if (tick_r >= eff_steps) begin
                if (!pair_left) begin
                  // playback ran past its last pair
                  seg_nxt   = '0;
                  play_nxt  = 1'b0;
                  done_nxt  = 1'b1;
                  state_nxt = ST_OUT;
                end else begin
                  seg_nxt       = seg_inc[SW-1:0];
                  tick_nxt      = '0;
                  load_pose_nxt = 1'b0;
                  state_nxt     = ST_RDA;
                end
              end else begin
                tick_nxt  = tick_r + STEP_W'(1);
                state_nxt = ST_ADD;
              end
            end
            default: begin
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_SAVE: begin
        if (last_ch) begin
          saved_nxt = saved_r + SCW'(1);
          state_nxt = ST_OUT;
        end else begin
          ch_nxt = ch_r + CH_W'(1);
        end
      end
      ST_RDA: begin
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        raddr     = addr_of(SCW'(seg_r) + SCW'(1), ch_r);
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_sts.done) begin
          if (last_ch) begin
            state_nxt = ST_OUT;
          end else begin
            ch_nxt    = ch_r + CH_W'(1);
            state_nxt = ST_RDA;
          end
        end
      end
      ST_ADD: begin
        if (last_ch) begin
          state_nxt = ST_OUT;
        end else begin
          ch_nxt = ch_r + CH_W'(1);
        end
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= STEPS_RESET;
    end else if (cfg_we) begin
      steps_r <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Keyframe memory: one write, one registered read per cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == ST_SAVE) begin
      mem[addr_of(saved_r, ch_r)] <= pin_r[ch_r];
    end
    rdata_r <= mem[raddr];
  end

  // --------------------------------------------------------------------------
  // Pose, increments and operand capture
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        pose_r[c] <= '0;
        inc_r[c]  <= '0;
      end
    end else begin
      if (accept && in_command == CMD_SAVE && save_ok) begin
        // a stored key also becomes the current pose
        for (int c = 0; c < NCH; c++) begin
          pose_r[c] <= in_ch[c];
        end
      end
      if (state_r == ST_RDB && load_pose_r) begin
        pose_r[ch_r] <= rdata_r;
      end
      if (state_r == ST_ADD) begin
        pose_r[ch_r] <= sum[CW-1:0];
      end
      if (state_r == ST_DIV && div_sts.done) begin
        inc_r[ch_r] <= div_q[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int c = 0; c < NCH; c++) begin
        pin_r[c] <= in_ch[c];
      end
    end
    if (state_r == ST_RDB) begin
      a_r <= rdata_r;
    end
  end

  // --------------------------------------------------------------------------
  // Result
  // --------------------------------------------------------------------------
  logic [31:0]   out_pose [NCH];
  logic [KW-1:0] keys_ext;

  for (genvar c = 0; c < NCH; c++) begin : g_out
    logic [EW-1:0] ext;
    assign ext         = EW'($signed(pose_r[c]));
    assign out_pose[c] = ext[31:0];
  end

  assign keys_ext        = KW'(saved_r);
  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_cur_x       = out_pose[0];
  assign out_cur_y       = out_pose[1];
  assign out_cur_z       = out_pose[2];
  assign out_cur_rot_a   = out_pose[3];
  assign out_cur_rot_b   = out_pose[4];
  assign out_is_playing  = play_r;
  assign out_keys_stored = keys_ext[3:0];
  assign out_finished    = done_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_finish_stops : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> !out_is_playing)
    else $error("finished while still playing");

  a_keys_bound : assert property (@(posedge clk) disable iff (!rst_n)
    saved_r <= SCW'(MAX_KEYS))
    else $error("key count beyond store depth");

  a_div_live : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> div_sts.busy || div_sts.done)
    else $error("waiting on an idle divider");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for keyframe_linear_interpolator_core
// Drives save, play and tick commands through the start/busy port and checks
// every result strobe against a cycle-free model of the keyframe player. It
// steps through several steps_per_segment settings and sender idle mixes.
// ----------------------------------------------------------------------------

typedef logic [4:0][31:0] pose_vec_t;

typedef struct packed {
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] z;
  logic [31:0] rot_a;
  logic [31:0] rot_b;
  logic        playing;
  logic [3:0]  keys;
  logic        finished;
} pose_frame_t;

// Keyframe player model plus the queue of frames still owed by the block.
class pose_scoreboard #(int KEY_SLOTS = 8);
  logic [31:0] key_mem [KEY_SLOTS][5];
  logic [31:0] pose [5];
  logic [31:0] incr [5];
  int unsigned ticks;
  int unsigned segment;
  int unsigned keys;
  bit          playing;
  logic [15:0] steps;
  pose_frame_t frame_q[$];
  int          errors;
  int          checked;
  int          finishes;

  function new();
    for (int c = 0; c < 5; c++) begin
      pose[c] = '0;
      incr[c] = '0;
    end
    ticks = 0;
    segment = 0;
    keys = 0;
    playing = 1'b0;
    steps = kfli_pkg::STEPS_RESET;
    errors = 0;
    checked = 0;
    finishes = 0;
  endfunction

  function int unsigned span();
    return (steps == 16'd0) ? 1 : int'(steps);
  endfunction

  // per-tick increment: neighbor difference, divided and truncated toward zero
  function void load_incr(int unsigned seg);
    longint d;
    for (int c = 0; c < 5; c++) begin
      d = longint'($signed(key_mem[seg + 1][c])) - longint'($signed(key_mem[seg][c]));
      d = d / longint'(span());
      incr[c] = d[31:0];
    end
  endfunction

  function void note_beat(logic [1:0] cmd, pose_vec_t p);
    pose_frame_t f;
    bit done;
    done = 1'b0;
    case (cmd)
      kfli_pkg::CMD_SAVE: begin
        if (keys < KEY_SLOTS) begin
          for (int c = 0; c < 5; c++) begin
            key_mem[keys][c] = p[c];
            pose[c] = p[c];
          end
          keys++;
        end
      end
      kfli_pkg::CMD_PLAY: begin
        if (!playing && keys >= 2) begin
          for (int c = 0; c < 5; c++) pose[c] = key_mem[0][c];
          segment = 0;
          load_incr(0);
          ticks = 0;
          playing = 1'b1;
        end else begin
          playing = 1'b0;
        end
      end
      kfli_pkg::CMD_TICK: begin
        if (playing) begin
          if (ticks >= span()) begin
            segment++;
            if (segment + 2 > keys) begin
              segment = 0;
              playing = 1'b0;
              done = 1'b1;
              finishes++;
            end else begin
              ticks = 0;
              load_incr(segment);
            end
          end else begin
            for (int c = 0; c < 5; c++) pose[c] = pose[c] + incr[c];
            ticks = (ticks + 1) & 16'hFFFF;
          end
        end
      end
      default: ;
    endcase
    f.x = pose[0];
    f.y = pose[1];
    f.z = pose[2];
    f.rot_a = pose[3];
    f.rot_b = pose[4];
    f.playing = playing;
    f.keys = keys[3:0];
    f.finished = done;
    frame_q.push_back(f);
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %0s: got %h want %h (result %0d)", what, got, want, checked);
    errors++;
  endtask

  task check_result(pose_frame_t got);
    pose_frame_t want;
    if (frame_q.size() == 0) begin
      report_mismatch("result strobe with nothing pending", 32'(got.keys), '0);
      return;
    end
    want = frame_q.pop_front();
    checked++;
    if (got.x !== want.x) report_mismatch("cur_x", got.x, want.x);
    if (got.y !== want.y) report_mismatch("cur_y", got.y, want.y);
    if (got.z !== want.z) report_mismatch("cur_z", got.z, want.z);
    if (got.rot_a !== want.rot_a) report_mismatch("cur_rot_a", got.rot_a, want.rot_a);
    if (got.rot_b !== want.rot_b) report_mismatch("cur_rot_b", got.rot_b, want.rot_b);
    if (got.playing !== want.playing)
      report_mismatch("is_playing", 32'(got.playing), 32'(want.playing));
    if (got.keys !== want.keys)
      report_mismatch("keys_stored", 32'(got.keys), 32'(want.keys));
    if (got.finished !== want.finished)
      report_mismatch("finished", 32'(got.finished), 32'(want.finished));
  endtask
endclass

module testbench;

  localparam logic [1:0] CMD_UNUSED = 2'd3;   // spare code, block must ignore it
  localparam int KEY_SLOTS   = 8;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 100;
  localparam int LINGER      = 250;           // > one full five-channel reload
  localparam int LIMIT       = 1000000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_command;
  logic signed [31:0]  in_pose_x;
  logic signed [31:0]  in_pose_y;
  logic signed [31:0]  in_pose_z;
  logic signed [31:0]  in_pose_rot_a;
  logic signed [31:0]  in_pose_rot_b;
  logic                out_valid;
  logic signed [31:0]  out_cur_x;
  logic signed [31:0]  out_cur_y;
  logic signed [31:0]  out_cur_z;
  logic signed [31:0]  out_cur_rot_a;
  logic signed [31:0]  out_cur_rot_b;
  logic                out_is_playing;
  logic [3:0]          out_keys_stored;
  logic                out_finished;
  logic                cfg_we;
  logic [kfli_pkg::STEP_W-1:0] cfg_wdata;

  pose_scoreboard #(KEY_SLOTS) sb;
  int   sender_idle_pct;
  int   beats;
  int   cycles;

  keyframe_linear_interpolator_core #(
    .MAX_KEYS     (KEY_SLOTS),
    .CHANNEL_BITS (32)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_pose_x       (in_pose_x),
    .in_pose_y       (in_pose_y),
    .in_pose_z       (in_pose_z),
    .in_pose_rot_a   (in_pose_rot_a),
    .in_pose_rot_b   (in_pose_rot_b),
    .out_valid       (out_valid),
    .out_cur_x       (out_cur_x),
    .out_cur_y       (out_cur_y),
    .out_cur_z       (out_cur_z),
    .out_cur_rot_a   (out_cur_rot_a),
    .out_cur_rot_b   (out_cur_rot_b),
    .out_is_playing  (out_is_playing),
    .out_keys_stored (out_keys_stored),
    .out_finished    (out_finished),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a lost or stuck beat ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Every strobe is a result: the block cannot be held off, so take it now.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result('{x: out_cur_x, y: out_cur_y, z: out_cur_z,
                        rot_a: out_cur_rot_a, rot_b: out_cur_rot_b,
                        playing: out_is_playing, keys: out_keys_stored,
                        finished: out_finished});
    end
  end

  // Bias channel values toward the wrap points, zero and small values; plain random otherwise.
  function automatic logic [31:0] rand_chan();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic pose_vec_t rand_pose();
    pose_vec_t p;
    for (int c = 0; c < 5; c++) p[c] = rand_chan();
    return p;
  endfunction

  // Present one command beat and hold it until the block takes it. Random
  // idle cycles go in front; start may rise while busy is still high.
  task automatic issue_command(input logic [1:0] cmd, input pose_vec_t p);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start         = 1'b1;
    in_command    = cmd;
    in_pose_x     = p[0];
    in_pose_y     = p[1];
    in_pose_z     = p[2];
    in_pose_rot_a = p[3];
    in_pose_rot_b = p[4];
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_beat(cmd, p);
    beats++;
  endtask

  // Drop start and wait until every owed frame is back and the block is idle.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.frame_q.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_steps(input logic [15:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.steps  = v;
  endtask

  // Pick the next command from the model state so that most beats are play
  // runs with ticks; a little noise (spare code, saves on a full store) too.
  task automatic random_beat(output bit counted);
    int r;
    logic [1:0] cmd;
    r = $urandom_range(99);
    if (sb.keys < KEY_SLOTS && r < 3) begin
      cmd = kfli_pkg::CMD_SAVE;
    end else if (r < 5) begin
      cmd = ($urandom_range(1)) ? CMD_UNUSED : kfli_pkg::CMD_SAVE;
    end else if (!sb.playing) begin
      cmd = ($urandom_range(99) < 60) ? kfli_pkg::CMD_PLAY : kfli_pkg::CMD_TICK;
    end else begin
      cmd = (r < 9) ? kfli_pkg::CMD_PLAY : kfli_pkg::CMD_TICK;
    end
    // only beats that move the player count toward the phase length
    counted = (cmd == kfli_pkg::CMD_PLAY) ||
              (cmd == kfli_pkg::CMD_TICK && sb.playing) ||
              (cmd == kfli_pkg::CMD_SAVE && sb.keys < KEY_SLOTS);
    issue_command(cmd, rand_pose());
  endtask

  initial begin
    pose_vec_t   junk;
    logic [15:0] plan [PHASES];
    int          done_in_phase;
    bit          counted;

    sb              = new();
    sender_idle_pct = 0;
    beats           = 0;
    cycles          = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_command      = kfli_pkg::CMD_TICK;
    in_pose_x       = '0;
    in_pose_y       = '0;
    in_pose_z       = '0;
    in_pose_rot_a   = '0;
    in_pose_rot_b   = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // ---- directed: empty store, extreme keys, mid-play save, play toggling
    write_steps(16'd2);
    junk = rand_pose();
    issue_command(kfli_pkg::CMD_TICK, junk);              // tick while idle
    issue_command(kfli_pkg::CMD_PLAY, junk);              // play, no keys yet
    issue_command(CMD_UNUSED, junk);                      // spare code
    issue_command(kfli_pkg::CMD_SAVE, {5{32'h7FFF_FFFF}});
    issue_command(kfli_pkg::CMD_PLAY, junk);              // play, one key only
    issue_command(kfli_pkg::CMD_SAVE, {5{32'h8000_0000}});
    issue_command(kfli_pkg::CMD_PLAY, junk);              // start, wraps on add
    repeat (3) issue_command(kfli_pkg::CMD_TICK, junk);   // last tick finishes
    issue_command(kfli_pkg::CMD_TICK, junk);              // idle again
    issue_command(kfli_pkg::CMD_PLAY, junk);
    issue_command(kfli_pkg::CMD_TICK, junk);
    // store a third key while playing; run continues with the longer list
    issue_command(kfli_pkg::CMD_SAVE,
                  {32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, $urandom, $urandom});
    repeat (3) issue_command(kfli_pkg::CMD_TICK, junk);   // segment change
    issue_command(kfli_pkg::CMD_PLAY, junk);              // play while playing
    issue_command(kfli_pkg::CMD_PLAY, junk);              // restart at pair 0
    repeat (4) issue_command(kfli_pkg::CMD_TICK, junk);

    // ---- random phases: one steps setting and one idle mix per phase
    plan = '{16'd1, 16'd3, 16'd0, 16'd65535, 16'd2, 16'd60,
             16'($urandom_range(1, 6)), 16'($urandom_range(4, 20))};
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_steps(plan[ph]);
      // result side cannot stall, so only the sender idles
      case (ph % 4)
        1:       sender_idle_pct = 58;
        3:       sender_idle_pct = 36;
        default: sender_idle_pct = 0;
      endcase
      done_in_phase = 0;
      while (done_in_phase < PHASE_BEATS) begin
        random_beat(counted);
        if (counted) done_in_phase++;
        // now and then pause the sender until the block has caught up
        if ($urandom_range(99) == 0) drain();
      end
    end

    drain();
    repeat (LINGER) @(negedge clk);
    if (sb.frame_q.size() != 0)
      sb.report_mismatch("frames still pending at end", sb.frame_q.size(), 0);

    $display("Run: %0d command beats over %0d steps settings (1, 0, 65535 included).",
             beats, PHASES + 1);
    $display("Checked %0d frames, %0d playbacks ran to completion, %0d mismatches.",
             sb.checked, sb.finishes, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
